// ===== sv/pmc_pkg.sv =====
`timescale 1ns / 1ps
// pmc_pkg: hash constants, transaction kinds, modular-add helper and the
// command/response structs of the shared modular multiplier. No dependencies.
package pmc_pkg;

   typedef logic [29:0] hash_type;

   localparam hash_type HBASE = 30'd1000005;
   localparam hash_type MOD_A = 30'd1000000007;
   localparam hash_type MOD_B = 30'd998244353;

   // req_tuser codes
   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   // one multiplier bit per cycle
   localparam int MUL_STEPS = 30;
   localparam int STEP_W    = 5;

   typedef struct packed {
      logic     start;
      hash_type xa;
      hash_type ya;
      hash_type xb;
      hash_type yb;
   } mul_cmd_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      hash_type ra;
      hash_type rb;
   } mul_rsp_type;

   // (a + b) mod m, both inputs below m
   function automatic hash_type add_mod(input hash_type a, input hash_type b,
                                        input hash_type m);
      logic [30:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[29:0];
   endfunction

endpackage

// ===== sv/pmc_modmul.sv =====
`timescale 1ns / 1ps
// pmc_modmul: bit-serial modular multiplier, both moduli side by side.
// Depends on pmc_pkg.
module pmc_modmul (
   input  logic                clock,
   input  logic                reset,
   input  pmc_pkg::mul_cmd_type cmd,
   output pmc_pkg::mul_rsp_type rsp
);
   import pmc_pkg::*;

   hash_type          xa_ff, ya_ff, ra_ff, xb_ff, yb_ff, rb_ff;
   hash_type          xa_in, ya_in, ra_in, xb_in, yb_in, rb_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   hash_type          dbl_a, dbl_b;

   // MSB first: r = 2r + bit*x, reduced after each add
   always_comb begin
      xa_in   = xa_ff;
      ya_in   = ya_ff;
      ra_in   = ra_ff;
      xb_in   = xb_ff;
      yb_in   = yb_ff;
      rb_in   = rb_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl_a   = add_mod(ra_ff, ra_ff, MOD_A);
      dbl_b   = add_mod(rb_ff, rb_ff, MOD_B);
      if (busy_ff) begin
         ra_in  = add_mod(dbl_a, ya_ff[29] ? xa_ff : '0, MOD_A);
         rb_in  = add_mod(dbl_b, yb_ff[29] ? xb_ff : '0, MOD_B);
         ya_in  = ya_ff << 1;
         yb_in  = yb_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         xa_in   = cmd.xa;
         ya_in   = cmd.ya;
         xb_in   = cmd.xb;
         yb_in   = cmd.yb;
         ra_in   = '0;
         rb_in   = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      xa_ff <= xa_in;
      ya_ff <= ya_in;
      ra_ff <= ra_in;
      xb_ff <= xb_in;
      yb_ff <= yb_in;
      rb_ff <= rb_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.ra   = ra_ff;
   assign rsp.rb   = rb_ff;

endmodule

// ===== sv/parameterized_match_counter_top.sv =====
`timescale 1ns / 1ps
// parameterized_match_counter_top: sequencer, symbol/ring memories and result stage.
// Depends on pmc_pkg and pmc_modmul.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  req     | in  | req_tvalid/tready  | tdata symbol, tuser kind, tlast end
//  rsp     | out | rsp_tvalid/tready  | tdata match/window_end/count, tlast done
//
// A modular multiply holds the sequencer for its issue, 30 bit steps and done.
// Pattern transaction: lookup, hash multiply, finish; no multiply once clipped.
// Text: lookup, link check once the window is full, then for a drop-out term
// square-and-multiply for base^(age-1) and a code multiply, then the hash multiply,
// all on the shared multiplier. Reset (sync, high), pattern end and text end sweep
// the last-seen memory, req_tready low; a text step waits while the result register is full.
module parameterized_match_counter_top #(
   parameter int MAX_PATTERN = 64,
   parameter int SYMBOL_BITS = 8,
   parameter int POS_BITS    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SYMBOL_BITS + 7) / 8) * 8-1:0] req_tdata,  // symbol
   input  logic                                  req_tuser,  // req_type
   input  logic                                  req_tlast,  // last
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [71:0]                           rsp_tdata,  // match, window_end, match_count
   output logic                                  rsp_tlast   // done_res
);
   import pmc_pkg::*;

   localparam int NSYM   = 1 << SYMBOL_BITS;
   localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int CW     = POS_BITS + LEN_W;
   localparam int ECW    = $clog2(SLOT_W + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LOOK  = 4'd2;
   localparam logic [3:0] S_LINK  = 4'd3;
   localparam logic [3:0] S_CODE  = 4'd4;
   localparam logic [3:0] S_PSQ   = 4'd5;
   localparam logic [3:0] S_PMB   = 4'd6;
   localparam logic [3:0] S_TERM  = 4'd7;
   localparam logic [3:0] S_HMUL  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   // memories
   logic [POS_BITS:0]   ls_mem [NSYM];         // {valid, last position}
   logic [POS_BITS-1:0] nl_mem [MAX_PATTERN];  // next_link ring
   logic [SLOT_W-1:0]   wc_mem [MAX_PATTERN];  // window code ring

   logic [POS_BITS:0]   ls_rd_ff, ls_wdata;
   logic [POS_BITS-1:0] nl_rd_ff, nl_wdata;
   logic [SLOT_W-1:0]   wc_rd_ff, wc_wdata;
   logic                ls_we, nl_we, wc_we;
   logic [SYMBOL_BITS-1:0] ls_waddr;
   logic [SLOT_W-1:0]   nl_waddr, nl_raddr, wc_waddr, wc_raddr;

   // control and state
   logic [3:0]             state_ff, state_in;
   logic [SYMBOL_BITS-1:0] clr_ff, clr_in, sym_ff, sym_in;
   logic                   lst_ff, lst_in, text_ff, text_in, mwait_ff, mwait_in;
   logic [LEN_W-1:0]       plen_ff, plen_in, fill_ff, fill_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [31:0]            count_ff, count_in;
   logic [SLOT_W-1:0]      wslot_ff, wslot_in, tslot_ff, tslot_in;
   logic [SLOT_W-1:0]      code_ff, code_in, tc_ff, tc_in, ex_ff, ex_in;
   logic [ECW-1:0]         ecnt_ff, ecnt_in;
   hash_type               pha_ff, pha_in, phb_ff, phb_in;
   hash_type               wha_ff, wha_in, whb_ff, whb_in;
   hash_type               powa_ff, powa_in, powb_ff, powb_in;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in, rsp_match_ff, rsp_match_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_end_ff, rsp_end_in, rsp_count_ff, rsp_count_in;

   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;

   logic [POS_BITS-1:0]    gap, age;
   logic                   hit;
   logic [LEN_W-1:0]       fill_new;
   logic                   full, match;
   logic [POS_BITS+31:0]   pos_ext;
   logic [SYMBOL_BITS-1:0] req_sym;

   // ring slot k places back from the write slot (k up to MAX_PATTERN)
   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] w,
                                                   input logic [LEN_W-1:0] k);
      logic [SLOT_W:0] dd, r;
      dd = (k == LEN_W'(MAX_PATTERN)) ? '0 : {1'b0, k[SLOT_W-1:0]};
      if ({1'b0, w} >= dd) begin
         r = {1'b0, w} - dd;
      end else begin
         r = {1'b0, w} + (SLOT_W + 1)'(MAX_PATTERN) - dd;
      end
      return r[SLOT_W-1:0];
   endfunction

   function automatic logic lt_len(input logic [POS_BITS-1:0] a,
                                   input logic [LEN_W-1:0] b);
      logic [CW-1:0] ax, bx;
      ax = CW'(a);
      bx = CW'(b);
      return ax < bx;
   endfunction

   pmc_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   assign req_sym  = req_tdata[SYMBOL_BITS-1:0];
   assign gap      = pos_ff - ls_rd_ff[POS_BITS-1:0];
   assign age      = pos_ff - nl_rd_ff;
   assign nl_raddr = slot_back(wslot_ff, plen_ff);
   assign wc_raddr = slot_back(wslot_ff, LEN_W'(age));
   assign pos_ext  = {32'd0, pos_ff};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sym_in       = sym_ff;
      lst_in       = lst_ff;
      text_in      = text_ff;
      mwait_in     = mwait_ff;
      plen_in      = plen_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      wslot_in     = wslot_ff;
      tslot_in     = tslot_ff;
      code_in      = code_ff;
      tc_in        = tc_ff;
      ex_in        = ex_ff;
      ecnt_in      = ecnt_ff;
      pha_in       = pha_ff;
      phb_in       = phb_ff;
      wha_in       = wha_ff;
      whb_in       = whb_ff;
      powa_in      = powa_ff;
      powb_in      = powb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_match_in = rsp_match_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      ls_we        = 1'b0;
      ls_waddr     = sym_ff;
      ls_wdata     = {1'b1, pos_ff};
      nl_we        = 1'b0;
      nl_waddr     = wslot_ff;
      nl_wdata     = pos_ff;
      wc_we        = 1'b0;
      wc_waddr     = wslot_ff;
      wc_wdata     = code_ff;
      mul_cmd      = '0;
      hit          = 1'b0;
      fill_new     = fill_ff;
      full         = 1'b0;
      match        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            ls_we    = 1'b1;
            ls_waddr = clr_ff;
            ls_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // wrong-kind transactions are taken and dropped
            if (req_tvalid &&
                (req_tuser == (text_ff ? KIND_TEXT : KIND_PATTERN))) begin
               sym_in   = req_sym;
               lst_in   = req_tlast;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (!text_ff) begin
               if (plen_ff < LEN_W'(MAX_PATTERN)) begin
                  hit      = ls_rd_ff[POS_BITS] && lt_len(gap, LEN_W'(MAX_PATTERN));
                  code_in  = hit ? SLOT_W'(gap) : '0;
                  ls_we    = 1'b1;
                  pos_in   = pos_ff + 1'b1;
                  plen_in  = plen_ff + 1'b1;
                  state_in = S_HMUL;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               hit     = ls_rd_ff[POS_BITS] && (gap != '0) && lt_len(gap, plen_ff);
               code_in = hit ? SLOT_W'(gap) : '0;
               if (hit) begin
                  nl_we    = 1'b1;
                  nl_waddr = slot_back(wslot_ff, LEN_W'(gap));
               end
               ls_we = 1'b1;
               if (fill_ff >= plen_ff && plen_ff != '0) begin
                  state_in = S_LINK;
               end else begin
                  state_in = S_HMUL;
               end
            end
         end
         S_LINK: begin
            // head leaves: the code pointing at it drops out of the window
            if (age != '0 && lt_len(age, plen_ff)) begin
               tslot_in = wc_raddr;
               ex_in    = SLOT_W'(age - 1'b1);
               state_in = S_CODE;
            end else begin
               state_in = S_HMUL;
            end
         end
         S_CODE: begin
            tc_in    = wc_rd_ff;
            wc_we    = 1'b1;
            wc_waddr = tslot_ff;
            wc_wdata = '0;
            powa_in  = hash_type'(1);
            powb_in  = hash_type'(1);
            ecnt_in  = ECW'(SLOT_W);
            state_in = S_PSQ;
         end
         S_PSQ, S_PMB: begin
            if (!mwait_ff) begin
               mul_cmd.start = 1'b1;
               mul_cmd.xa    = powa_ff;
               mul_cmd.xb    = powb_ff;
               mul_cmd.ya    = (state_ff == S_PSQ) ? powa_ff : HBASE;
               mul_cmd.yb    = (state_ff == S_PSQ) ? powb_ff : HBASE;
               mwait_in      = 1'b1;
            end else if (mul_rsp.done) begin
               powa_in  = mul_rsp.ra;
               powb_in  = mul_rsp.rb;
               mwait_in = 1'b0;
               if (state_ff == S_PSQ && ex_ff[SLOT_W-1]) begin
                  state_in = S_PMB;
               end else begin
                  ex_in    = ex_ff << 1;
                  ecnt_in  = ecnt_ff - 1'b1;
                  state_in = (ecnt_ff == ECW'(1)) ? S_TERM : S_PSQ;
               end
            end
         end
         S_TERM: begin
            if (!mwait_ff) begin
               mul_cmd.start = 1'b1;
               mul_cmd.xa    = hash_type'(tc_ff);
               mul_cmd.xb    = hash_type'(tc_ff);
               mul_cmd.ya    = powa_ff;
               mul_cmd.yb    = powb_ff;
               mwait_in      = 1'b1;
            end else if (mul_rsp.done) begin
               wha_in   = add_mod(wha_ff, MOD_A - mul_rsp.ra, MOD_A);
               whb_in   = add_mod(whb_ff, MOD_B - mul_rsp.rb, MOD_B);
               mwait_in = 1'b0;
               state_in = S_HMUL;
            end
         end
         S_HMUL: begin
            if (!mwait_ff) begin
               mul_cmd.start = 1'b1;
               mul_cmd.xa    = text_ff ? wha_ff : pha_ff;
               mul_cmd.xb    = text_ff ? whb_ff : phb_ff;
               mul_cmd.ya    = HBASE;
               mul_cmd.yb    = HBASE;
               mwait_in      = 1'b1;
            end else if (mul_rsp.done) begin
               mwait_in = 1'b0;
               if (text_ff) begin
                  wha_in = add_mod(mul_rsp.ra, hash_type'(code_ff), MOD_A);
                  whb_in = add_mod(mul_rsp.rb, hash_type'(code_ff), MOD_B);
               end else begin
                  pha_in = add_mod(mul_rsp.ra, hash_type'(code_ff), MOD_A);
                  phb_in = add_mod(mul_rsp.rb, hash_type'(code_ff), MOD_B);
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!text_ff) begin
               if (lst_ff) begin
                  pos_in   = '0;
                  wha_in   = '0;
                  whb_in   = '0;
                  wslot_in = '0;
                  fill_in  = '0;
                  count_in = '0;
                  text_in  = 1'b1;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (!rsp_valid_ff || rsp_tready) begin
               wc_we    = 1'b1;
               nl_we    = 1'b1;
               fill_new = (fill_ff < plen_ff) ? fill_ff + 1'b1 : fill_ff;
               full     = fill_new >= plen_ff;
               match    = full && wha_ff == pha_ff && whb_ff == phb_ff;
               count_in = (match && count_ff != '1) ? count_ff + 1'b1 : count_ff;
               if (full || lst_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_match_in = match;
                  rsp_end_in   = pos_ext[31:0];
                  rsp_count_in = count_in;
                  rsp_last_in  = lst_ff;
               end
               if (lst_ff) begin
                  // job done: back to the reset state
                  pha_in   = '0;
                  phb_in   = '0;
                  wha_in   = '0;
                  whb_in   = '0;
                  plen_in  = '0;
                  pos_in   = '0;
                  count_in = '0;
                  wslot_in = '0;
                  fill_in  = '0;
                  text_in  = 1'b0;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  wslot_in = (wslot_ff == SLOT_W'(MAX_PATTERN - 1)) ? '0 : wslot_ff + 1'b1;
                  pos_in   = pos_ff + 1'b1;
                  fill_in  = fill_new;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ls_we) begin
         ls_mem[ls_waddr] <= ls_wdata;
      end
      ls_rd_ff <= ls_mem[req_sym];
      if (nl_we) begin
         nl_mem[nl_waddr] <= nl_wdata;
      end
      nl_rd_ff <= nl_mem[nl_raddr];
      if (wc_we) begin
         wc_mem[wc_waddr] <= wc_wdata;
      end
      wc_rd_ff <= wc_mem[wc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         text_ff      <= 1'b0;
         mwait_ff     <= 1'b0;
         plen_ff      <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         wslot_ff     <= '0;
         pha_ff       <= '0;
         phb_ff       <= '0;
         wha_ff       <= '0;
         whb_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         text_ff      <= text_in;
         mwait_ff     <= mwait_in;
         plen_ff      <= plen_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         wslot_ff     <= wslot_in;
         pha_ff       <= pha_in;
         phb_ff       <= phb_in;
         wha_ff       <= wha_in;
         whb_ff       <= whb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff       <= sym_in;
      lst_ff       <= lst_in;
      tslot_ff     <= tslot_in;
      code_ff      <= code_in;
      tc_ff        <= tc_in;
      ex_ff        <= ex_in;
      ecnt_ff      <= ecnt_in;
      powa_ff      <= powa_in;
      powb_ff      <= powb_in;
      rsp_match_ff <= rsp_match_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_end_ff, rsp_match_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // multiplier result only arrives while the sequencer waits for it
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> mwait_ff)
      else $error("multiplier done without a pending request");

   // window fill never passes the pattern length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      text_ff |-> (fill_ff <= plen_ff))
      else $error("window fill beyond pattern length");

   // stored pattern length stays within the ring
   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond ring depth");
`endif

endmodule

// ===== sim/tb_parameterized_match_counter_top.sv =====
`timescale 1ns / 1ps
// tb_parameterized_match_counter_top: self-checking bench for the parameterized-match
// counter; predicts every result transaction from its own copy of the hash state.
// Depends on pmc_pkg and parameterized_match_counter_top.
module tb_parameterized_match_counter_top;
   import pmc_pkg::*;

   localparam int    RING      = 64;
   localparam int    NSYM      = 256;
   localparam int    DRAIN     = 1200;     // worst text transaction plus a sweep
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct {
      bit          match;
      logic [31:0] window_end;
      logic [31:0] match_count;
      bit          done;
   } verdict_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser, req_tlast;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [71:0] rsp_tdata;

   parameterized_match_counter_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   // Mirror of the block's hash state; advanced once per accepted transaction.
   longint unsigned pat_ha, pat_hb, win_ha, win_hb;
   logic [31:0]     seen_pos [NSYM];
   bit              seen_ok  [NSYM];
   longint unsigned ring_code [RING];
   logic [31:0]     ring_link [RING];
   int unsigned     pat_len, wr_slot, win_fill;
   logic [31:0]     cur_pos, hit_count;
   bit              text_phase;

   verdict_type     pending_q[$];
   int              fail_count;
   int              items_sent;
   int              send_idle_pct, recv_stall_pct;

   function automatic void clear_matcher();
      pat_ha = 0; pat_hb = 0; win_ha = 0; win_hb = 0;
      for (int i = 0; i < NSYM; i++) begin
         seen_pos[i] = '0;
         seen_ok[i]  = 1'b0;
      end
      for (int i = 0; i < RING; i++) begin
         ring_code[i] = 0;
         ring_link[i] = '0;
      end
      pat_len = 0; wr_slot = 0; win_fill = 0;
      cur_pos = '0; hit_count = '0; text_phase = 1'b0;
   endfunction

   function automatic longint unsigned base_pow(input longint unsigned e,
                                                input longint unsigned m);
      longint unsigned r, b;
      r = 1;
      b = HBASE % m;
      while (e != 0) begin
         if (e[0]) r = r * b % m;
         e = e >> 1;
         b = b * b % m;
      end
      return r;
   endfunction

   function automatic int unsigned ring_back(input longint unsigned d);
      return (wr_slot + RING - int'(d % RING)) % RING;
   endfunction

   // Returns 1 when the transaction yields a result transaction.
   function automatic bit predict_window(input bit kind, input logic [7:0] sym,
                                         input bit lst, output verdict_type v);
      longint unsigned code, e, c;
      logic [31:0]     p, gap;
      int unsigned     s;
      bit              was_full, full;
      v = '{default: 0};
      if (!text_phase) begin
         if (kind != KIND_PATTERN) return 0;
         if (pat_len < RING) begin
            code = 0;
            if (seen_ok[sym]) begin
               gap = cur_pos - seen_pos[sym];
               if (gap < RING) code = gap;
            end
            pat_ha = (pat_ha * HBASE + code) % MOD_A;
            pat_hb = (pat_hb * HBASE + code) % MOD_B;
            seen_pos[sym] = cur_pos;
            seen_ok[sym]  = 1'b1;
            cur_pos++;
            pat_len++;
         end
         if (lst) begin
            for (int i = 0; i < NSYM; i++) seen_ok[i] = 1'b0;
            for (int i = 0; i < RING; i++) begin
               ring_code[i] = 0;
               ring_link[i] = '0;
            end
            cur_pos = '0; win_ha = 0; win_hb = 0;
            wr_slot = 0; win_fill = 0; hit_count = '0;
            text_phase = 1'b1;
         end
         return 0;
      end
      if (kind != KIND_TEXT) return 0;
      p = cur_pos;
      code = 0;
      was_full = win_fill >= pat_len;
      if (seen_ok[sym]) begin
         gap = p - seen_pos[sym];
         if (gap > 0 && gap < pat_len) begin
            code = gap;
            ring_link[ring_back(gap)] = p;
         end
      end
      // oldest element drops out: zero the code that referred back to it
      if (was_full && pat_len > 0) begin
         gap = p - ring_link[ring_back(pat_len)];
         e = gap;
         if (e > 0 && e < pat_len) begin
            s = ring_back(e);
            c = ring_code[s];
            win_ha = (win_ha + MOD_A - c * base_pow(e - 1, MOD_A) % MOD_A) % MOD_A;
            win_hb = (win_hb + MOD_B - c * base_pow(e - 1, MOD_B) % MOD_B) % MOD_B;
            ring_code[s] = 0;
         end
      end
      win_ha = (win_ha * HBASE + code) % MOD_A;
      win_hb = (win_hb * HBASE + code) % MOD_B;
      ring_code[wr_slot] = code;
      ring_link[wr_slot] = p;
      seen_pos[sym] = p;
      seen_ok[sym]  = 1'b1;
      wr_slot = (wr_slot + 1) % RING;
      cur_pos = p + 1;
      if (win_fill < pat_len) win_fill++;
      if (!(win_fill >= pat_len || lst)) return 0;
      full = win_fill >= pat_len;
      v.match = full && win_ha == pat_ha && win_hb == pat_hb;
      if (v.match && hit_count != 32'hFFFF_FFFF) hit_count++;
      v.window_end  = p;
      v.match_count = hit_count;
      v.done        = lst;
      if (lst) clear_matcher();
      return 1;
   endfunction

   // ---------------------------------------------------------------- driver
   // Holds valid across back-to-back transactions; drops it only for a gap.
   task automatic send_symbol(input bit kind, input logic [7:0] sym, input bit lst);
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= sym;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      if (predict_window(kind, sym, lst, v)) pending_q.push_back(v);
      items_sent++;
   endtask

   task automatic send_pattern(input logic [7:0] pat[$]);
      foreach (pat[i]) send_symbol(KIND_PATTERN, pat[i], i == pat.size() - 1);
   endtask

   task automatic send_text(input logic [7:0] txt[$]);
      foreach (txt[i]) send_symbol(KIND_TEXT, txt[i], i == txt.size() - 1);
   endtask

   // ---------------------------------------------------------------- checker
   // Each result transaction is compared with the oldest prediction.
   longint cycle_count;
   verdict_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         cycle_count <= 0;
      end else begin
         rsp_tready  <= ($urandom_range(99) >= recv_stall_pct);
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results pending", $time, pending_q.size());
            $display("FAIL");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.match       = rsp_tdata[0];
            got.window_end  = rsp_tdata[32:1];
            got.match_count = rsp_tdata[64:33];
            got.done        = rsp_tlast;
            if (pending_q.size() == 0) begin
               $display("%0t unexpected result: match %0d end %0d count %0d done %0d",
                        $time, got.match, got.window_end, got.match_count, got.done);
               fail_count++;
            end else begin
               want = pending_q.pop_front();
               if (got.match != want.match || got.window_end != want.window_end ||
                   got.match_count != want.match_count || got.done != want.done ||
                   rsp_tdata[71:65] != '0) begin
                  $display("%0t mismatch: expected match %0d end %0d count %0d done %0d",
                           $time, want.match, want.window_end, want.match_count,
                           want.done);
                  $display("%0t           actual   match %0d end %0d count %0d done %0d",
                           $time, got.match, got.window_end, got.match_count, got.done);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Pattern with both symbol extremes; text holds two relabeled copies.
   task automatic test_basic_match();
      send_pattern('{8'h00, 8'hFF, 8'h00, 8'h00});
      send_text('{8'h12, 8'h80, 8'h34, 8'h80, 8'h80, 8'h07, 8'h12, 8'h07, 8'h07, 8'h55});
   endtask

   // Text transaction during pattern load and pattern transaction during text: ignored.
   task automatic test_wrong_kind();
      send_symbol(KIND_TEXT, 8'hAA, 1'b1);
      send_symbol(KIND_PATTERN, 8'h01, 1'b0);
      send_symbol(KIND_PATTERN, 8'h02, 1'b1);
      send_symbol(KIND_TEXT, 8'h03, 1'b0);
      send_symbol(KIND_PATTERN, 8'h09, 1'b1);
      send_symbol(KIND_TEXT, 8'h04, 1'b1);
   endtask

   // Text ends before a window fills: one result with a zero count.
   task automatic test_short_text();
      send_pattern('{8'h05, 8'h06, 8'h07});
      send_text('{8'h01, 8'hFE});
   endtask

   // Pattern beyond ring depth is clipped to its first 64 symbols.
   task automatic test_long_pattern();
      logic [7:0] pat[$], txt[$];
      for (int i = 0; i < 70; i++) pat.push_back(8'(i % 5));
      for (int i = 0; i < 66; i++) txt.push_back(8'(8'hF0 + i % 5));
      send_pattern(pat);
      send_text(txt);
   endtask

   // Random jobs: mostly relabeled pattern copies, some noise and stray kinds.
   task automatic test_random_jobs(input int target);
      logic [7:0] pat[$], txt[$], alpha[4];
      int         m, tlen, seg;
      logic [7:0] key;
      while (items_sent < target) begin
         send_idle_pct  = (items_sent / 60) % 4 == 1 ? 59 :
                          (items_sent / 60) % 4 == 3 ? 34 : 0;
         recv_stall_pct = (items_sent / 60) % 4 == 2 ? 59 :
                          (items_sent / 60) % 4 == 3 ? 34 : 0;
         pat.delete();
         txt.delete();
         for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
         m = ($urandom_range(9) == 0) ? $urandom_range(9, 68) : $urandom_range(1, 8);
         for (int i = 0; i < m; i++) pat.push_back(alpha[$urandom_range(3)]);
         tlen = $urandom_range(1, 3 * m + 6);
         if (m > 20) tlen = $urandom_range(1, m + 8);
         while (txt.size() < tlen) begin
            if ($urandom_range(3) != 0) begin
               key = 8'($urandom);
               seg = $urandom_range(1, m);
               for (int i = 0; i < seg && txt.size() < tlen; i++)
                  txt.push_back(pat[i] ^ key);
            end else begin
               txt.push_back(($urandom_range(4) == 0) ? 8'($urandom) :
                             alpha[$urandom_range(3)]);
            end
         end
         if ($urandom_range(7) == 0) send_symbol(KIND_TEXT, 8'($urandom), 1'($urandom));
         send_pattern(pat);
         if ($urandom_range(7) == 0) send_symbol(KIND_PATTERN, 8'($urandom), 1'($urandom));
         send_text(txt);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tuser      = 1'b0;
      req_tlast      = 1'b0;
      req_tdata      = '0;
      fail_count     = 0;
      items_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      clear_matcher();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_match();
      test_wrong_kind();
      test_short_text();
      test_long_pattern();
      test_random_jobs(550);

      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pmc_pkg.sv
sv/pmc_modmul.sv
sv/parameterized_match_counter_top.sv
sim/tb_parameterized_match_counter_top.sv
